// ----- hdl/hbs_pkg.sv -----
`timescale 1ns / 1ps

package hbs_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;

  localparam int unsigned CFG_W     = 9;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam int unsigned COORD_W = 17;
  localparam logic [COORD_W-1:0] ONE_Q16 = 17'h10000;

  // accept edge to the edge that takes the result
  localparam int unsigned LATENCY = 5;

  localparam logic [31:0] HEIGHT_MAX = 32'hFFFF0000;

endpackage

// ----- hdl/heightmap_bilinear_sampler.sv -----
// Pipelined bilinear heightmap sampler, four row/column parity banks read in parallel.
// Throughput: one transfer (write or query) per cycle, busy is never raised.
// The result strobe follows the query through q1_q, q2_q, q3_q, q4_q and res_vld_q.
// A write is seen by any query taken in the following cycle or later.
// Reset (async, active low) clears the pipeline valids and sizes; sample memory is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module heightmap_bilinear_sampler #(
  parameter int unsigned MAX_WIDTH  = hbs_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = hbs_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hbs_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           start,
  output logic                           busy,
  input  logic                           mode_i,
  input  logic [7:0]                     col_i,
  input  logic [7:0]                     row_i,
  input  logic [15:0]                    sample_i,
  input  logic signed [31:0]             u_pos_i,
  input  logic signed [31:0]             v_pos_i,
  output logic                           result_valid_o,
  output logic [31:0]                    height_q16_o
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned HCW = (CW > 1) ? CW - 1 : 1;
  localparam int unsigned HRW = (RW > 1) ? RW - 1 : 1;
  localparam int unsigned AW  = HCW + HRW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned EWC = (CW + 1 > hbs_pkg::CFG_W) ? CW + 1 : hbs_pkg::CFG_W;
  localparam int unsigned EWR = (RW + 1 > hbs_pkg::CFG_W) ? RW + 1 : hbs_pkg::CFG_W;
  localparam int unsigned XW  = hbs_pkg::COORD_W + CW;
  localparam int unsigned YW  = hbs_pkg::COORD_W + RW;

  // ---------------- configuration
  logic [hbs_pkg::CFG_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hbs_pkg::CFG_IDX_WIDTH:  width_q  <= cfg_wdata_i;
        hbs_pkg::CFG_IDX_HEIGHT: height_q <= cfg_wdata_i;
      endcase
    end
  end

  logic [EWC-1:0] w_ext, w_sat;
  logic [EWR-1:0] h_ext, h_sat;
  logic [CW-1:0]  wm1;
  logic [RW-1:0]  hm1;
  logic           no_data;

  always_comb begin
    w_ext   = EWC'(width_q);
    h_ext   = EWR'(height_q);
    w_sat   = (w_ext > EWC'(MAX_WIDTH))  ? EWC'(MAX_WIDTH)  : w_ext;
    h_sat   = (h_ext > EWR'(MAX_HEIGHT)) ? EWR'(MAX_HEIGHT) : h_ext;
    no_data = (width_q == '0) || (height_q == '0);
    wm1     = (w_sat == '0) ? '0 : CW'(w_sat - EWC'(1));
    hm1     = (h_sat == '0) ? '0 : RW'(h_sat - EWR'(1));
  end

  // ---------------- accept stage: clamp and scale
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  logic [hbs_pkg::COORD_W-1:0] u_cl, v_cl;

  always_comb begin
    if (u_pos_i[31])
      u_cl = '0;
    else if (u_pos_i > $signed({15'd0, hbs_pkg::ONE_Q16}))
      u_cl = hbs_pkg::ONE_Q16;
    else
      u_cl = u_pos_i[hbs_pkg::COORD_W-1:0];
    if (v_pos_i[31])
      v_cl = '0;
    else if (v_pos_i > $signed({15'd0, hbs_pkg::ONE_Q16}))
      v_cl = hbs_pkg::ONE_Q16;
    else
      v_cl = v_pos_i[hbs_pkg::COORD_W-1:0];
  end

  logic [XW-1:0] fx_d;
  logic [YW-1:0] fy_d;
  assign fx_d = XW'(u_cl) * XW'(wm1);
  assign fy_d = YW'(v_cl) * YW'(hm1);

  logic          wr_ok;
  logic [CW-1:0] wr_x;
  logic [RW-1:0] wr_y;
  assign wr_ok = (EWC'(col_i) < EWC'(MAX_WIDTH)) && (EWR'(row_i) < EWR'(MAX_HEIGHT));
  assign wr_x  = CW'(col_i);
  assign wr_y  = RW'(row_i);

  function automatic logic [HCW-1:0] half_x(input logic [CW-1:0] x);
    half_x = HCW'(x >> 1);
  endfunction

  function automatic logic [HRW-1:0] half_y(input logic [RW-1:0] y);
    half_y = HRW'(y >> 1);
  endfunction

  logic          q1_q, wr1_q;
  logic [XW-1:0] fx_q;
  logic [YW-1:0] fy_q;
  logic [1:0]    wr_bank_q;
  logic [AW-1:0] wr_addr_q;
  logic [15:0]   wr_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q1_q  <= 1'b0;
      wr1_q <= 1'b0;
    end else begin
      q1_q  <= accept && (mode_i == hbs_pkg::MODE_QUERY);
      wr1_q <= accept && (mode_i == hbs_pkg::MODE_WRITE) && wr_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    fx_q      <= fx_d;
    fy_q      <= fy_d;
    wr_bank_q <= {wr_y[0], wr_x[0]};
    wr_addr_q <= {half_y(wr_y), half_x(wr_x)};
    wr_data_q <= sample_i;
  end

  // ---------------- stage 1: cell, neighbors, bank reads / write
  logic [CW-1:0] x1, xn1;
  logic [RW-1:0] y1, yn1;
  logic          xsat1, ysat1;
  logic [AW-1:0] rd_addr [4];

  always_comb begin
    x1    = fx_q[16 +: CW];
    y1    = fy_q[16 +: RW];
    xsat1 = !(x1 < wm1);
    ysat1 = !(y1 < hm1);
    xn1   = xsat1 ? x1 : x1 + CW'(1);
    yn1   = ysat1 ? y1 : y1 + RW'(1);
    for (int b = 0; b < 4; b++) begin
      rd_addr[b] = {half_y((y1[0] == b[1]) ? y1 : yn1),
                    half_x((x1[0] == b[0]) ? x1 : xn1)};
    end
  end

  logic [15:0] rd_q [4];

  for (genvar g = 0; g < 4; g++) begin : g_bank
    logic [15:0] bank_mem [DEPTH];

    always_ff @(posedge clk_i) begin
      if (wr1_q && (wr_bank_q == 2'(g)))
        bank_mem[wr_addr_q] <= wr_data_q;
      rd_q[g] <= bank_mem[rd_addr[g]];
    end
  end

  logic        q2_q, x0_2_q, y0_2_q, xsat2_q, ysat2_q;
  logic [15:0] ax2_q, ay2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)
      q2_q <= 1'b0;
    else
      q2_q <= q1_q;
  end

  always_ff @(posedge clk_i) begin
    x0_2_q  <= x1[0];
    y0_2_q  <= y1[0];
    xsat2_q <= xsat1;
    ysat2_q <= ysat1;
    ax2_q   <= fx_q[15:0];
    ay2_q   <= fy_q[15:0];
  end

  // ---------------- stage 2: horizontal blend
  logic [15:0]        h00, h10, h01, h11;
  logic signed [16:0] dtop, dbot;
  logic signed [33:0] ptop, pbot, top_d, bot_d;

  always_comb begin
    h00 = rd_q[{y0_2_q, x0_2_q}];
    h10 = xsat2_q ? h00 : rd_q[{y0_2_q, ~x0_2_q}];
    h01 = ysat2_q ? h00 : rd_q[{~y0_2_q, x0_2_q}];
    h11 = xsat2_q ? h01 : (ysat2_q ? h10 : rd_q[{~y0_2_q, ~x0_2_q}]);
    dtop  = $signed({1'b0, h10}) - $signed({1'b0, h00});
    dbot  = $signed({1'b0, h11}) - $signed({1'b0, h01});
    ptop  = dtop * $signed({1'b0, ax2_q});
    pbot  = dbot * $signed({1'b0, ax2_q});
    top_d = $signed({2'b00, h00, 16'h0000}) + ptop;
    bot_d = $signed({2'b00, h01, 16'h0000}) + pbot;
  end

  logic               q3_q;
  logic signed [33:0] top3_q, bot3_q;
  logic [15:0]        ay3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)
      q3_q <= 1'b0;
    else
      q3_q <= q2_q;
  end

  always_ff @(posedge clk_i) begin
    top3_q <= top_d;
    bot3_q <= bot_d;
    ay3_q  <= ay2_q;
  end

  // ---------------- stage 3: vertical weight
  logic signed [33:0] dv;
  logic signed [50:0] pv_d;
  assign dv   = bot3_q - top3_q;
  assign pv_d = dv * $signed({1'b0, ay3_q});

  logic               q4_q;
  logic signed [33:0] top4_q;
  logic signed [50:0] pv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)
      q4_q <= 1'b0;
    else
      q4_q <= q3_q;
  end

  always_ff @(posedge clk_i) begin
    top4_q <= top3_q;
    pv_q   <= pv_d;
  end

  // ---------------- stage 4: floor shift, clamp, output register
  logic signed [50:0] fin;
  logic [31:0]        res_d;

  always_comb begin
    fin = $signed({{17{top4_q[33]}}, top4_q}) + (pv_q >>> 16);
    if (no_data || fin[50])
      res_d = '0;
    else
      res_d = fin[31:0];
  end

  logic        res_vld_q;
  logic [31:0] res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)
      res_vld_q <= 1'b0;
    else
      res_vld_q <= q4_q;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_vld_q;
  assign height_q16_o   = res_q;

endmodule

// ----- hdl/hbs_checker.sv -----
`timescale 1ns / 1ps

module hbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        mode_i,
  input logic        result_valid_o,
  input logic [31:0] height_q16_o
);

  logic query_xfer;
  assign query_xfer = start && !busy && (mode_i == hbs_pkg::MODE_QUERY);

  a_query_gets_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_xfer |-> ##(hbs_pkg::LATENCY) result_valid_o)
    else $error("query transfer without result");

  a_result_has_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && $past(rst_ni, hbs_pkg::LATENCY)
      |-> $past(query_xfer, hbs_pkg::LATENCY))
    else $error("result without a matching query");

  a_height_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (height_q16_o <= hbs_pkg::HEIGHT_MAX))
    else $error("height out of range");

endmodule

bind heightmap_bilinear_sampler hbs_checker u_hbs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .mode_i         (mode_i),
  .result_valid_o (result_valid_o),
  .height_q16_o   (height_q16_o)
);
